// ===== design/acr_pkg.sv =====
package acr_pkg;

    // Item kinds carried on the mode field
    typedef enum logic [1:0] {
        MODE_RX    = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_SEND  = 2'd2
    } t_mode;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Register select on paddr[3]
    typedef enum logic {
        REG_LOCAL_IP  = 1'b0,
        REG_LOCAL_MAC = 1'b1
    } t_reg;

    localparam logic [15:0] MIN_PKT_LEN = 16'd28;
    localparam logic [15:0] RX_OP_REQUEST = 16'd1;
    localparam logic [1:0]  TX_OP_REQUEST = 2'd1;
    localparam logic [1:0]  TX_OP_REPLY   = 2'd2;
    localparam logic [47:0] BCAST_MAC     = 48'hFFFF_FFFF_FFFF;

    // Registered read data of one cache entry
    typedef struct packed {
        logic        entry_valid;
        logic [31:0] ip;
        logic [47:0] mac;
    } t_cache_rd;

    // Write of one binding
    typedef struct packed {
        logic        en;
        logic [31:0] ip;
        logic [47:0] mac;
    } t_cache_wr;

endpackage

// ===== design/acr_cache.sv =====
module acr_cache
    import acr_pkg::*;
#(
    parameter int CACHE_ENTRIES = 16,
    parameter int IDX_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_cache_rd        o_rd,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_cache_wr        i_wr
);

    logic [31:0]              r_ip_mem  [CACHE_ENTRIES];
    logic [47:0]              r_mac_mem [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] r_valid;
    t_cache_rd                r_rd;

    // Write the binding storage; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_ip_mem[i_wr_addr]  <= i_wr.ip;
            r_mac_mem[i_wr_addr] <= i_wr.mac;
        end
    end

    // Clear valid bits at reset, set on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Register the read port every cycle
    always_ff @(posedge i_clk) begin
        r_rd.entry_valid <= r_valid[i_rd_addr];
        r_rd.ip          <= r_ip_mem[i_rd_addr];
        r_rd.mac         <= r_mac_mem[i_rd_addr];
    end

    assign o_rd = r_rd;

endmodule

// ===== design/acr_seq.sv =====
module acr_seq
    import acr_pkg::*;
#(
    parameter int CACHE_ENTRIES = 16,
    parameter int IDX_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_in_mode,
    input  logic [15:0]      i_in_packet_length,
    input  logic [15:0]      i_in_rx_opcode,
    input  logic [31:0]      i_in_rx_sender_ip,
    input  logic [47:0]      i_in_rx_sender_mac,
    input  logic [31:0]      i_in_tgt_ip,
    input  logic [31:0]      i_in_query_ip,
    input  logic [31:0]      i_local_ip,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_out_send_packet,
    output logic [1:0]       o_out_send_opcode,
    output logic [47:0]      o_out_dest_mac,
    output logic [47:0]      o_out_send_target_mac,
    output logic [31:0]      o_out_send_tgt_ip,
    output logic             o_out_lookup_hit,
    output logic [47:0]      o_out_lookup_mac,
    // cache port
    output logic [IDX_W-1:0] o_rd_addr,
    input  t_cache_rd        i_rd,
    output logic [IDX_W-1:0] o_wr_addr,
    output t_cache_wr        o_wr
);

    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CACHE_ENTRIES);

    t_state           r_state, n_state;
    logic [1:0]       r_mode;
    logic             r_live;
    logic             r_reply;
    logic [31:0]      r_key;
    logic [31:0]      r_sip;
    logic [47:0]      r_smac;
    logic [31:0]      r_tip;
    logic [CNT_W-1:0] r_idx;
    logic             r_pend;
    logic [IDX_W-1:0] r_pidx;
    logic             r_hit;
    logic [47:0]      r_lmac;

    logic             r_o_valid;
    logic             r_o_send_packet;
    logic [1:0]       r_o_send_opcode;
    logic [47:0]      r_o_dest_mac;
    logic [47:0]      r_o_send_target_mac;
    logic [31:0]      r_o_send_tgt_ip;
    logic             r_o_lookup_hit;
    logic [47:0]      r_o_lookup_mac;

    logic accept;
    logic issue;
    logic key_match;
    logic qualify;
    logic found;
    logic scan_end;
    logic out_free;
    logic load_out;
    logic scan_go;

    // Shared comparator and entry qualification
    assign key_match = (i_rd.ip == r_key);
    always_comb begin
        if (r_mode == MODE_QUERY) begin
            qualify = i_rd.entry_valid && key_match;
        end else begin
            qualify = !i_rd.entry_valid || key_match;
        end
    end

    assign out_free = !r_o_valid || !i_out_stall;
    assign scan_go  = !((i_in_mode == MODE_RX) && (i_in_packet_length < MIN_PKT_LEN))
                      && ((i_in_mode == MODE_RX) || (i_in_mode == MODE_QUERY));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = scan_go ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (found || scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall = 1'b1;
        accept     = 1'b0;
        issue      = 1'b0;
        found      = 1'b0;
        scan_end   = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                accept     = i_in_valid;
            end
            ST_SCAN: begin
                found    = r_pend && qualify;
                scan_end = !r_pend && (r_idx == LAST_CNT);
                issue    = !found && (r_idx < LAST_CNT);
            end
            ST_DONE: begin
                load_out = out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    assign o_rd_addr = r_idx[IDX_W-1:0];
    assign o_wr_addr = r_pidx;
    assign o_wr.en   = found && (r_mode == MODE_RX);
    assign o_wr.ip   = r_sip;
    assign o_wr.mac  = r_smac;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_in_mode;
            r_live  <= !((i_in_mode == MODE_RX) && (i_in_packet_length < MIN_PKT_LEN));
            r_reply <= (i_in_rx_opcode == RX_OP_REQUEST) && (i_in_tgt_ip == i_local_ip);
            r_key   <= (i_in_mode == MODE_QUERY) ? i_in_query_ip : i_in_rx_sender_ip;
            r_sip   <= i_in_rx_sender_ip;
            r_smac  <= i_in_rx_sender_mac;
            r_tip   <= i_in_tgt_ip;
        end
    end

    // Advance the scan counter and the compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_pend <= 1'b0;
        end else if (accept) begin
            r_idx  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= issue;
            if (issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pidx <= r_idx[IDX_W-1:0];
        end
    end

    // Hold the lookup result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hit  <= 1'b0;
            r_lmac <= '0;
        end else if (found && (r_mode == MODE_QUERY)) begin
            r_hit  <= 1'b1;
            r_lmac <= i_rd.mac;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    // Build the result
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_send_packet     <= 1'b0;
            r_o_send_opcode     <= '0;
            r_o_dest_mac        <= '0;
            r_o_send_target_mac <= '0;
            r_o_send_tgt_ip     <= '0;
            r_o_lookup_hit      <= 1'b0;
            r_o_lookup_mac      <= '0;
            if (r_live) begin
                case (r_mode)
                    MODE_RX: begin
                        if (r_reply) begin
                            r_o_send_packet     <= 1'b1;
                            r_o_send_opcode     <= TX_OP_REPLY;
                            r_o_dest_mac        <= r_smac;
                            r_o_send_target_mac <= r_smac;
                            r_o_send_tgt_ip     <= r_sip;
                        end
                    end
                    MODE_QUERY: begin
                        r_o_lookup_hit <= r_hit;
                        r_o_lookup_mac <= r_lmac;
                    end
                    MODE_SEND: begin
                        r_o_send_packet <= 1'b1;
                        r_o_send_opcode <= TX_OP_REQUEST;
                        r_o_dest_mac    <= BCAST_MAC;
                        r_o_send_tgt_ip <= r_tip;
                    end
                    default: r_o_send_packet <= 1'b0;
                endcase
            end
        end
    end

    assign o_out_valid           = r_o_valid;
    assign o_out_send_packet     = r_o_send_packet;
    assign o_out_send_opcode     = r_o_send_opcode;
    assign o_out_dest_mac        = r_o_dest_mac;
    assign o_out_send_target_mac = r_o_send_target_mac;
    assign o_out_send_tgt_ip     = r_o_send_tgt_ip;
    assign o_out_lookup_hit      = r_o_lookup_hit;
    assign o_out_lookup_mac      = r_o_lookup_mac;

endmodule

// ===== design/arp_cache_responder.sv =====
// A send request, a dropped packet or an unused mode goes from idle straight to the
// done state; a received packet or resolve query first scans the cache, which reads
// one entry per cycle through one read port and comparator. A new request is taken
// only after the previous result enters the output register, so result stalls hold it off.
// Reset (synchronous, active low) invalidates all cache entries at once and
// clears local_ip and local_mac; no clearing pass is needed.
module arp_cache_responder
    import acr_pkg::*;
#(
    parameter int CACHE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_in_mode,
    input  logic [15:0] i_in_packet_length,
    input  logic [15:0] i_in_rx_opcode,
    input  logic [31:0] i_in_rx_sender_ip,
    input  logic [47:0] i_in_rx_sender_mac,
    input  logic [31:0] i_in_tgt_ip,
    input  logic [31:0] i_in_query_ip,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_out_send_packet,
    output logic [1:0]  o_out_send_opcode,
    output logic [47:0] o_out_dest_mac,
    output logic [47:0] o_out_send_target_mac,
    output logic [31:0] o_out_send_tgt_ip,
    output logic        o_out_lookup_hit,
    output logic [47:0] o_out_lookup_mac
);

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    logic [31:0]      r_local_ip;
    logic [47:0]      r_local_mac;
    logic             cfg_wr;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    t_cache_rd        cache_rd;
    t_cache_wr        cache_wr;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip  <= '0;
            r_local_mac <= '0;
        end else if (cfg_wr) begin
            case (t_reg'(paddr[3]))
                REG_LOCAL_IP:  r_local_ip  <= pwdata[31:0];
                REG_LOCAL_MAC: r_local_mac <= pwdata[47:0];
                default:       r_local_ip  <= r_local_ip;
            endcase
        end
    end

    always_comb begin
        case (t_reg'(paddr[3]))
            REG_LOCAL_IP:  prdata = {32'd0, r_local_ip};
            REG_LOCAL_MAC: prdata = {16'd0, r_local_mac};
            default:       prdata = '0;
        endcase
    end

    acr_cache #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_cache (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd      (cache_rd),
        .i_wr_addr (wr_addr),
        .i_wr      (cache_wr)
    );

    acr_seq #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_seq (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_in_mode             (i_in_mode),
        .i_in_packet_length    (i_in_packet_length),
        .i_in_rx_opcode        (i_in_rx_opcode),
        .i_in_rx_sender_ip     (i_in_rx_sender_ip),
        .i_in_rx_sender_mac    (i_in_rx_sender_mac),
        .i_in_tgt_ip           (i_in_tgt_ip),
        .i_in_query_ip         (i_in_query_ip),
        .i_local_ip            (r_local_ip),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_out_send_packet     (o_out_send_packet),
        .o_out_send_opcode     (o_out_send_opcode),
        .o_out_dest_mac        (o_out_dest_mac),
        .o_out_send_target_mac (o_out_send_target_mac),
        .o_out_send_tgt_ip     (o_out_send_tgt_ip),
        .o_out_lookup_hit      (o_out_lookup_hit),
        .o_out_lookup_mac      (o_out_lookup_mac),
        .o_rd_addr             (rd_addr),
        .i_rd                  (cache_rd),
        .o_wr_addr             (wr_addr),
        .o_wr                  (cache_wr)
    );

endmodule

// ===== design/acr_checker.sv =====
module acr_checker
    import acr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_out_send_packet,
    input logic [1:0]  o_out_send_opcode,
    input logic [47:0] o_out_dest_mac,
    input logic [47:0] o_out_send_target_mac,
    input logic [31:0] o_out_send_tgt_ip,
    input logic        o_out_lookup_hit,
    input logic [47:0] o_out_lookup_mac
);

    // One request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while busy");

    // Stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_send_opcode)
            && $stable(o_out_dest_mac) && $stable(o_out_lookup_mac)))
        else $error("stalled result changed");

    // No packet means no packet fields
    a_idle_send_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_send_packet) |-> (o_out_send_opcode == 2'd0
            && o_out_dest_mac == 48'd0 && o_out_send_tgt_ip == 32'd0))
        else $error("send fields set without a packet");

    // Lookup hit and transmission are exclusive
    a_hit_no_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_lookup_hit) |-> !o_out_send_packet)
        else $error("lookup hit together with a sent packet");

    // A request always goes to broadcast with zero target MAC
    a_request_bcast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_send_opcode == TX_OP_REQUEST) |->
            (o_out_dest_mac == BCAST_MAC && o_out_send_target_mac == 48'd0))
        else $error("request not broadcast");

endmodule

bind arp_cache_responder acr_checker u_acr_checker (.*);
